@@ rtl/core/imh_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// imh_pkg
// Shared types and constants of the indexed min-heap: request and status
// codes, read-address selects, and the command/status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int DEF_MAX_ITEMS   = 1024;
  localparam int DEF_SCORE_WIDTH = 16;
  localparam int ID_W            = 10;
  localparam int ID_SPACE        = 1024;
  localparam int SCORE_IN_W      = 16;
  localparam int COUNT_W         = 11;
  localparam int STATUS_W        = 2;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_POP    = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_PEEK   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_EMPTY  = 2'd1,
    STS_REJECT = 2'd2,
    STS_NOMEMB = 2'd3
  } sts_e;

  // heap read address select
  typedef enum logic [2:0] {
    HRA_ZERO = 3'd0,
    HRA_LAST = 3'd1,
    HRA_UP   = 3'd2,
    HRA_CH   = 3'd3,
    HRA_CH1  = 3'd4
  } heap_ra_e;

  typedef struct packed {
    logic     accept;
    logic     clr;
    logic     chk;
    logic     pop_item;
    logic     pop_root;
    logic     ld_mov;
    logic     ld_key;
    logic     up_lat;
    logic     up_step;
    logic     place;
    logic     dn_left;
    logic     dn_right;
    logic     dn_step;
    logic     load_out;
    heap_ra_e heap_ra;
    logic     score_ra_heap;
  } imh_cmd_t;

  typedef struct packed {
    req_e req;
    logic member;
    logic full;
    logic empty;
    logic last_one;
    logic clr_done;
    logic p_zero;
    logic leaf;
    logic up_less;
    logic dn_swap;
    logic out_free;
  } imh_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/imh_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// imh_ctrl
// Sequencer of the heap: membership clear after reset, lookup, pop fetch,
// sift up, sift down and result hand-off.
// ----------------------------------------------------------------------------
module imh_ctrl import imh_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire imh_sts_t sts_i,
  output imh_cmd_t      cmd_o
);

  typedef enum logic [17:0] {
    S_CLR    = 18'h00001,
    S_IDLE   = 18'h00002,
    S_LOOKUP = 18'h00004,
    S_CHECK1 = 18'h00008,
    S_CHECK2 = 18'h00010,
    S_POP_R1 = 18'h00020,
    S_POP_R2 = 18'h00040,
    S_POP_R3 = 18'h00080,
    S_POP_R4 = 18'h00100,
    S_UP_CHK = 18'h00200,
    S_UP_RD  = 18'h00400,
    S_UP_CMP = 18'h00800,
    S_PLACE  = 18'h01000,
    S_DN_CHK = 18'h02000,
    S_DN_RL  = 18'h04000,
    S_DN_RR  = 18'h08000,
    S_DN_SR  = 18'h10000,
    S_FIN    = 18'h20000
  } state_e;

  state_e state_q, state_d;
  logic   do_down_q, do_down_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    do_down_d = do_down_q;
    cmd_o     = '0;
    cmd_o.heap_ra = HRA_ZERO;
    cmd_o.score_ra_heap = 1'b1;
    case (state_q)
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: state_d = S_CHECK1;
      S_CHECK1: begin
        cmd_o.score_ra_heap = 1'b0;
        state_d = S_CHECK2;
      end
      S_CHECK2: begin
        cmd_o.chk = 1'b1;
        case (sts_i.req)
          REQ_INSERT: begin
            do_down_d = 1'b0;
            state_d = (sts_i.member || sts_i.full) ? S_FIN : S_UP_CHK;
          end
          REQ_POP:    state_d = sts_i.empty ? S_FIN : S_POP_R1;
          REQ_UPDATE: begin
            do_down_d = 1'b1;
            state_d = sts_i.member ? S_UP_CHK : S_FIN;
          end
          default:    state_d = S_FIN;
        endcase
      end
      S_POP_R1: begin
        cmd_o.pop_item = 1'b1;
        state_d = S_POP_R2;
      end
      S_POP_R2: begin
        cmd_o.pop_root = 1'b1;
        cmd_o.heap_ra = HRA_LAST;
        do_down_d = 1'b0;
        state_d = sts_i.last_one ? S_FIN : S_POP_R3;
      end
      S_POP_R3: begin
        cmd_o.ld_mov = 1'b1;
        state_d = S_POP_R4;
      end
      S_POP_R4: begin
        cmd_o.ld_key = 1'b1;
        state_d = S_DN_CHK;
      end
      S_UP_CHK: begin
        cmd_o.heap_ra = HRA_UP;
        state_d = sts_i.p_zero ? S_PLACE : S_UP_RD;
      end
      S_UP_RD: begin
        cmd_o.up_lat = 1'b1;
        state_d = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (sts_i.up_less) begin
          cmd_o.up_step = 1'b1;
          state_d = S_UP_CHK;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        if (do_down_q) begin
          do_down_d = 1'b0;
          state_d = S_DN_CHK;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DN_CHK: begin
        cmd_o.heap_ra = HRA_CH;
        state_d = sts_i.leaf ? S_PLACE : S_DN_RL;
      end
      S_DN_RL: begin
        cmd_o.dn_left = 1'b1;
        cmd_o.heap_ra = HRA_CH1;
        state_d = S_DN_RR;
      end
      S_DN_RR: begin
        cmd_o.dn_right = 1'b1;
        state_d = S_DN_SR;
      end
      S_DN_SR: begin
        if (sts_i.dn_swap) begin
          cmd_o.dn_step = 1'b1;
          state_d = S_DN_CHK;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      do_down_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      do_down_q <= do_down_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/imh_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// imh_dpath
// Heap, position, score and membership memories with the sift registers,
// result registers and the output register.
// ----------------------------------------------------------------------------
module imh_dpath import imh_pkg::*; #(
  parameter int MAX_ITEMS   = DEF_MAX_ITEMS,
  parameter int SCORE_WIDTH = DEF_SCORE_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [1:0]            req_type_i,
  input  wire logic [ID_W-1:0]       item_id_i,
  input  wire logic [SCORE_IN_W-1:0] score_i,
  input  wire logic                  out_ready_i,
  input  wire imh_cmd_t              cmd_i,
  output imh_sts_t                   sts_o,
  output logic                       out_valid_o,
  output logic [ID_W-1:0]            out_item_o,
  output logic [SCORE_IN_W-1:0]      out_score_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [COUNT_W-1:0]         count_o
);

  localparam int Cap = (MAX_ITEMS < ID_SPACE) ? MAX_ITEMS : ID_SPACE;
  localparam int IW  = $clog2(Cap);
  localparam int CW  = $clog2(Cap + 1);
  localparam int CHW = IW + 2;
  localparam int SW  = SCORE_WIDTH;

  // memories
  logic [ID_W-1:0] heap_mem  [Cap];
  logic [IW-1:0]   pos_mem   [ID_SPACE];
  logic [SW-1:0]   score_mem [ID_SPACE];
  logic            flag_mem  [ID_SPACE];

  logic [ID_W-1:0] heap_rd_q;
  logic [IW-1:0]   pos_rd_q;
  logic [SW-1:0]   score_rd_q;
  logic            flag_rd_q;

  // request and sift registers
  req_e            req_q;
  logic [ID_W-1:0] id_q, mov_q, other_q, lid_q, rid_q, res_item_q;
  logic [SW-1:0]   sc_q, key_q, lsc_q, res_score_q;
  sts_e            res_status_q;
  logic [IW-1:0]   p_q;
  logic [CW-1:0]   count_q, count_d;
  logic [ID_W-1:0] clr_q;
  logic            out_valid_q, out_valid_d;

  logic [31:0]     sc_wide, res_wide;
  logic [IW-1:0]   p_m1, up_idx, heap_ra, pick_ch;
  logic [CW-1:0]   last_full;
  logic [CHW-1:0]  ch, ch1, cnt_ext;
  logic [ID_W-1:0] score_ra, pick_id, hw_id, fw_addr;
  logic [SW-1:0]   pick_sc;
  logic            has_right, pick_right, hw_we, fw_en, fw_val;
  logic            member, full, empty, ins_ok, upd_ok;

  assign sc_wide   = 32'(score_i);
  assign res_wide  = 32'(res_score_q);
  assign p_m1      = p_q - IW'(1);
  assign up_idx    = p_m1 >> 1;
  assign ch        = (CHW'(p_q) << 1) + CHW'(1);
  assign ch1       = ch + CHW'(1);
  assign cnt_ext   = CHW'(count_q);
  assign last_full = count_q - CW'(1);

  always_comb begin
    case (cmd_i.heap_ra)
      HRA_ZERO: heap_ra = '0;
      HRA_LAST: heap_ra = last_full[IW-1:0];
      HRA_UP:   heap_ra = up_idx;
      HRA_CH:   heap_ra = ch[IW-1:0];
      HRA_CH1:  heap_ra = ch1[IW-1:0];
      default:  heap_ra = '0;
    endcase
  end

  assign score_ra   = cmd_i.score_ra_heap ? heap_rd_q : id_q;

  // child choice: left wins an equal score
  assign has_right  = (ch1 < cnt_ext);
  assign pick_right = has_right && (lsc_q > score_rd_q);
  assign pick_id    = pick_right ? rid_q : lid_q;
  assign pick_sc    = pick_right ? score_rd_q : lsc_q;
  assign pick_ch    = pick_right ? ch1[IW-1:0] : ch[IW-1:0];

  assign hw_we = cmd_i.place | cmd_i.up_step | cmd_i.dn_step;
  assign hw_id = cmd_i.place ? mov_q : (cmd_i.up_step ? other_q : pick_id);

  assign member = flag_rd_q;
  assign full   = (count_q >= CW'(Cap));
  assign empty  = (count_q == '0);
  assign ins_ok = (req_q == REQ_INSERT) && !member && !full;
  assign upd_ok = (req_q == REQ_UPDATE) && member;

  always_comb begin
    fw_en   = 1'b0;
    fw_addr = id_q;
    fw_val  = 1'b0;
    if (cmd_i.clr) begin
      fw_en   = 1'b1;
      fw_addr = clr_q;
    end else if (cmd_i.chk && ins_ok) begin
      fw_en  = 1'b1;
      fw_val = 1'b1;
    end else if (cmd_i.pop_root) begin
      fw_en   = 1'b1;
      fw_addr = res_item_q;
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.req      = req_q;
    sts_o.member   = member;
    sts_o.full     = full;
    sts_o.empty    = empty;
    sts_o.last_one = (count_q == CW'(1));
    sts_o.clr_done = (clr_q == '1);
    sts_o.p_zero   = (p_q == '0);
    sts_o.leaf     = (ch >= cnt_ext);
    sts_o.up_less  = (key_q < score_rd_q);
    sts_o.dn_swap  = (key_q > pick_sc);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // memory ports: registered reads
  always_ff @(posedge clk_i) begin
    heap_rd_q <= heap_mem[heap_ra];
    if (hw_we) heap_mem[p_q] <= hw_id;
  end

  always_ff @(posedge clk_i) begin
    pos_rd_q <= pos_mem[id_q];
    if (hw_we) pos_mem[hw_id] <= p_q;
  end

  always_ff @(posedge clk_i) begin
    score_rd_q <= score_mem[score_ra];
    if (cmd_i.chk && (ins_ok || upd_ok)) score_mem[id_q] <= sc_q;
  end

  always_ff @(posedge clk_i) begin
    flag_rd_q <= flag_mem[id_q];
    if (fw_en) flag_mem[fw_addr] <= fw_val;
  end

  // control registers
  always_comb begin
    count_d = count_q;
    if (cmd_i.chk && ins_ok) count_d = count_q + CW'(1);
    else if (cmd_i.pop_root) count_d = count_q - CW'(1);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.clr) clr_q <= clr_q + ID_W'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_e'(req_type_i);
      id_q  <= item_id_i;
      sc_q  <= sc_wide[SW-1:0];
    end
    if (cmd_i.chk) begin
      res_item_q   <= id_q;
      res_score_q  <= '0;
      res_status_q <= STS_OK;
      case (req_q)
        REQ_INSERT: begin
          if (member) begin
            res_score_q  <= score_rd_q;
            res_status_q <= STS_REJECT;
          end else if (full) begin
            res_status_q <= STS_REJECT;
          end else begin
            res_score_q <= sc_q;
            p_q   <= count_q[IW-1:0];
            key_q <= sc_q;
            mov_q <= id_q;
          end
        end
        REQ_POP: begin
          if (empty) begin
            res_item_q   <= '0;
            res_status_q <= STS_EMPTY;
          end
        end
        REQ_UPDATE: begin
          if (member) begin
            res_score_q <= sc_q;
            p_q   <= pos_rd_q;
            key_q <= sc_q;
            mov_q <= id_q;
          end else begin
            res_status_q <= STS_NOMEMB;
          end
        end
        default: begin
          if (member) res_score_q <= score_rd_q;
        end
      endcase
    end
    if (cmd_i.pop_item) res_item_q <= heap_rd_q;
    if (cmd_i.pop_root) res_score_q <= score_rd_q;
    if (cmd_i.ld_mov) begin
      mov_q <= heap_rd_q;
      p_q   <= '0;
    end
    if (cmd_i.ld_key) key_q <= score_rd_q;
    if (cmd_i.up_lat) other_q <= heap_rd_q;
    if (cmd_i.up_step) p_q <= up_idx;
    if (cmd_i.dn_left) lid_q <= heap_rd_q;
    if (cmd_i.dn_right) begin
      rid_q <= heap_rd_q;
      lsc_q <= score_rd_q;
    end
    if (cmd_i.dn_step) p_q <= pick_ch;
    if (cmd_i.load_out) begin
      out_item_o  <= res_item_q;
      out_score_o <= res_wide[SCORE_IN_W-1:0];
      status_o    <= res_status_q;
      count_o     <= COUNT_W'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

@@ rtl/core/indexed_min_heap.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap of item ids keyed by a per-item score, with a
// position map so any member's score can be changed in place.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake               | payload
//   --------+-----+-------------------------+----------------------------------
//   request | in  | in_valid_i / in_ready_o | req_type_i item_id_i score_i
//   result  | out | out_valid_o/out_ready_i | out_item_o out_score_o status_o
//           |     |                         | count_o
//
// Flow: one request at a time. Lookup reads the membership flag, position and
// score; sift up reads and compares one parent per level climbed, sift down
// reads both children and compares per level descended; then the moving id is
// placed and the result handed on. A pop first fetches root and last entry.
// Every step is bound by one registered read of the heap or score memory.
// Reset: after rst_ni releases, a clearing pass walks the 1024 membership
// flags, one per cycle; in_ready_o stays low until the pass is done.
// Stalls: the result sits in an output register, so the next request is taken
// while an earlier result still waits for its transfer; a new result waits
// only if the register is still occupied.
//
module indexed_min_heap import imh_pkg::*; #(
  parameter int MAX_ITEMS   = DEF_MAX_ITEMS,
  parameter int SCORE_WIDTH = DEF_SCORE_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            req_type_i,
  input  wire logic [ID_W-1:0]       item_id_i,
  input  wire logic [SCORE_IN_W-1:0] score_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [ID_W-1:0]            out_item_o,
  output logic [SCORE_IN_W-1:0]      out_score_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [COUNT_W-1:0]         count_o
);

  // command and status bundles between sequencer and datapath
  imh_cmd_t cmd;
  imh_sts_t sts;

  imh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  imh_dpath #(
    .MAX_ITEMS   (MAX_ITEMS),
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_type_i  (req_type_i),
    .item_id_i   (item_id_i),
    .score_i     (score_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_score_o (out_score_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

endmodule
`default_nettype wire

@@ sim/indexed_min_heap_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_min_heap_checker
// Watches both channels of the indexed min-heap, keeps its own heap, map and
// score table, predicts one result per request transfer and compares it
// field by field with the results that come out, oldest first.
// ----------------------------------------------------------------------------
module indexed_min_heap_checker import imh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [1:0]            req_type_i,
  input  logic [ID_W-1:0]       item_id_i,
  input  logic [SCORE_IN_W-1:0] score_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [ID_W-1:0]       out_item_i,
  input  logic [SCORE_IN_W-1:0] out_score_i,
  input  logic [STATUS_W-1:0]   status_i,
  input  logic [COUNT_W-1:0]    count_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    results_seen_o
);

  typedef struct packed {
    logic [ID_W-1:0]       item;
    logic [SCORE_IN_W-1:0] score;
    sts_e                  status;
    logic [COUNT_W-1:0]    count;
  } heap_result_t;

  logic [ID_W-1:0]       heap_q [ID_SPACE];
  logic [ID_W-1:0]       slot_of [ID_SPACE];
  logic [SCORE_IN_W-1:0] key_of [ID_SPACE];
  logic                  is_member [ID_SPACE];
  int unsigned           members;
  heap_result_t          expected_q [$];

  assign pending_o = expected_q.size();

  function automatic void put(int unsigned p, logic [ID_W-1:0] id);
    heap_q[p]   = id;
    slot_of[id] = ID_W'(p);
  endfunction

  function automatic void bubble_up(int unsigned p);
    logic [ID_W-1:0] id;
    int unsigned     up;
    id = heap_q[p];
    while (p > 0) begin
      up = (p - 1) / 2;
      if (key_of[id] >= key_of[heap_q[up]]) break;
      put(p, heap_q[up]);
      p = up;
    end
    put(p, id);
  endfunction

  function automatic void bubble_down(int unsigned p);
    logic [ID_W-1:0] id;
    int unsigned     ch;
    id = heap_q[p];
    while (2 * p + 1 < members) begin
      ch = 2 * p + 1;
      // left child wins a tie
      if (ch + 1 < members && key_of[heap_q[ch]] > key_of[heap_q[ch + 1]]) ch++;
      if (key_of[id] <= key_of[heap_q[ch]]) break;
      put(p, heap_q[ch]);
      p = ch;
    end
    put(p, id);
  endfunction

  function automatic heap_result_t apply_request(req_e req, logic [ID_W-1:0] id,
                                                 logic [SCORE_IN_W-1:0] sc);
    heap_result_t r;
    r = '{item: id, score: '0, status: STS_OK, count: '0};
    case (req)
      REQ_INSERT: begin
        if (is_member[id]) begin
          r.score  = key_of[id];
          r.status = STS_REJECT;
        end else if (members >= ID_SPACE) begin
          r.status = STS_REJECT;
        end else begin
          key_of[id]    = sc;
          is_member[id] = 1'b1;
          heap_q[members] = id;
          members++;
          bubble_up(members - 1);
          r.score = sc;
        end
      end
      REQ_POP: begin
        if (members == 0) begin
          r.item   = '0;
          r.status = STS_EMPTY;
        end else begin
          r.item  = heap_q[0];
          r.score = key_of[r.item];
          is_member[r.item] = 1'b0;
          members--;
          if (members > 0) begin
            heap_q[0] = heap_q[members];
            bubble_down(0);
          end
        end
      end
      REQ_UPDATE: begin
        if (!is_member[id]) begin
          r.status = STS_NOMEMB;
        end else begin
          key_of[id] = sc;
          bubble_up(slot_of[id]);
          bubble_down(slot_of[id]);
          r.score = sc;
        end
      end
      default: if (is_member[id]) r.score = key_of[id];
    endcase
    r.count = COUNT_W'(members);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o   = 0;
    results_seen_o = 0;
    members        = 0;
    foreach (is_member[i]) is_member[i] = 1'b0;
  end

  always @(posedge clk_i) begin
    heap_result_t w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        expected_q.push_back(apply_request(req_e'(req_type_i), item_id_i, score_i));
      if (out_valid_i && out_ready_i) begin
        results_seen_o++;
        if (expected_q.size() == 0) begin
          $display("[%0t] result transfer with nothing expected", $time);
          fail_count_o++;
        end else begin
          w = expected_q.pop_front();
          if (out_item_i != w.item)
            report_mismatch("out_item", int'(out_item_i), int'(w.item));
          if (out_score_i != w.score)
            report_mismatch("out_score", int'(out_score_i), int'(w.score));
          if (status_i != w.status)
            report_mismatch("status", int'(status_i), int'(w.status));
          if (count_i != w.count)
            report_mismatch("count", int'(count_i), int'(w.count));
        end
      end
    end
  end

endmodule

@@ sim/indexed_min_heap_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_min_heap_test
// Drives requests into the indexed min-heap with random gaps and random
// result back-pressure; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module indexed_min_heap_test;
  import imh_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;  // idle cycles, covers the clearing pass
  localparam int RANDOM_ITEMS   = 120;
  localparam int DRAIN_POPS     = 100;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            req_type_i;
  logic [ID_W-1:0]       item_id_i;
  logic [SCORE_IN_W-1:0] score_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [ID_W-1:0]       out_item_o;
  logic [SCORE_IN_W-1:0] out_score_o;
  logic [STATUS_W-1:0]   status_o;
  logic [COUNT_W-1:0]    count_o;

  int fail_count;
  int pending;
  int results_seen;
  int idle_cycles;
  int pops_sent;
  int inserts_sent;
  int updates_sent;
  bit back_pressure_on;

  // local copy of membership only, to steer stimulus towards useful ids
  bit          live_id [ID_SPACE];
  int unsigned live_count;

  indexed_min_heap u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .item_id_i,
    .score_i, .out_valid_o, .out_ready_i, .out_item_o, .out_score_o,
    .status_o, .count_o
  );

  indexed_min_heap_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .req_type_i,
    .item_id_i, .score_i, .out_valid_i(out_valid_o), .out_ready_i,
    .out_item_i(out_item_o), .out_score_i(out_score_o), .status_i(status_o),
    .count_i(count_o), .fail_count_o(fail_count), .pending_o(pending),
    .results_seen_o(results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure; switched off for stretches
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!back_pressure_on) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 99) < 65);
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(10, 60)) @(posedge clk_i);
      end
    end
  end

  initial begin
    back_pressure_on = 1'b1;
    forever begin
      repeat ($urandom_range(200, 800)) @(posedge clk_i);
      back_pressure_on = ~back_pressure_on;
    end
  end

  // watchdog: cycles without any transfer
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", pending);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // one request transfer; the payload holds until accepted
  task automatic send_request(req_e req, logic [ID_W-1:0] id,
                              logic [SCORE_IN_W-1:0] sc);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    item_id_i  <= id;
    score_i    <= sc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // track membership the way the heap will see it
    case (req)
      REQ_INSERT: begin
        inserts_sent++;
        if (!live_id[id] && live_count < ID_SPACE) begin
          live_id[id] = 1'b1;
          live_count++;
        end
      end
      REQ_POP:    pops_sent++;
      REQ_UPDATE: updates_sent++;
      default: ;
    endcase
  endtask

  // pops need to know the popped id, so refresh membership from results
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i && status_o == STS_OK && live_id[out_item_o]
        && 32'(count_o) < live_count)
      if (live_count > 0) begin
        live_id[out_item_o] = 1'b0;
        live_count--;
      end
  end

  function automatic logic [ID_W-1:0] pick_live_id();
    logic [ID_W-1:0] id;
    id = ID_W'($urandom);
    for (int i = 0; i < ID_SPACE; i++) begin
      if (live_id[id]) return id;
      id++;
    end
    return id;
  endfunction

  function automatic logic [SCORE_IN_W-1:0] rand_score();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel < 5) return SCORE_IN_W'($urandom_range(0, 15));  // lots of equal keys
    return SCORE_IN_W'($urandom);
  endfunction

  initial begin
    int sel;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_INSERT;
    item_id_i    = '0;
    score_i      = '0;
    pops_sent    = 0;
    inserts_sent = 0;
    updates_sent = 0;
    live_count   = 0;
    foreach (live_id[i]) live_id[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty pop, non-member update, extremes, ties, duplicates
    send_request(REQ_POP, '0, '0);
    send_request(REQ_UPDATE, 10'd5, 16'd7);
    send_request(REQ_PEEK, 10'd5, '0);
    send_request(REQ_INSERT, '1, '1);
    send_request(REQ_INSERT, '0, '0);
    send_request(REQ_INSERT, 10'd3, 16'd100);
    send_request(REQ_INSERT, 10'd4, 16'd100);
    send_request(REQ_INSERT, 10'd5, 16'd100);
    send_request(REQ_INSERT, 10'd3, 16'd1);
    send_request(REQ_PEEK, 10'd3, '0);
    send_request(REQ_UPDATE, '1, '0);
    send_request(REQ_UPDATE, '0, '1);
    send_request(REQ_UPDATE, 10'd4, 16'hAAAA);
    send_request(REQ_UPDATE, 10'd5, 16'h5555);
    repeat (7) send_request(REQ_POP, '0, '0);

    // fill to capacity once, then a full reject and 40 updates on live ids, then drain part of it
    for (int i = 0; i < ID_SPACE; i++) send_request(REQ_INSERT, i[ID_W-1:0], rand_score());
    send_request(REQ_INSERT, 10'd77, 16'd1);
    for (int i = 0; i < 40; i++) send_request(REQ_UPDATE, pick_live_id(), rand_score());
    for (int i = 0; i < DRAIN_POPS; i++) send_request(REQ_POP, '0, '0);

    // random: mostly well-formed traffic on live ids, some noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40)
        send_request(REQ_INSERT, live_count < 64 ? ID_W'($urandom) : pick_live_id(),
                     rand_score());
      else if (sel < 65)
        send_request(REQ_POP, ID_W'($urandom), SCORE_IN_W'($urandom));
      else if (sel < 90)
        send_request(REQ_UPDATE,
                     (live_count > 0 && sel < 86) ? pick_live_id() : ID_W'($urandom),
                     rand_score());
      else
        send_request(REQ_PEEK, ID_W'($urandom), SCORE_IN_W'($urandom));
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("covered %0d inserts, %0d pops, %0d updates; %0d results checked",
             inserts_sent, pops_sent, updates_sent, results_seen);
    $display("including a fill to full capacity, rejects, empty pops and equal keys");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
